### hw/rtl/ddo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MUL_W     = 34;
  localparam int unsigned PROD_W    = 2 * MUL_W;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned DVS_W     = 23;
  localparam int unsigned TRIG_W    = 34;
  localparam int unsigned CORDIC_STEPS = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 22;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INPUT_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_REV = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AXLE_TRACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd4;

  // input modes, the unused code behaves as radians
  localparam logic [1:0] MODE_TICKS    = 2'd0;
  localparam logic [1:0] MODE_RADIANS  = 2'd1;
  localparam logic [1:0] MODE_DISTANCE = 2'd2;

  localparam logic [15:0] TICKS_RESET  = 16'd500;
  localparam logic [19:0] RADIUS_RESET = 20'd4260;
  localparam logic [21:0] TRACK_RESET  = 22'd21627;
  localparam logic [15:0] RATE_RESET   = 16'd100;

  // 2pi in Q16.16 and radians to binary turns
  localparam logic signed [MUL_W-1:0] TWO_PI_Q    = 34'sd411774;
  localparam logic signed [MUL_W-1:0] RAD_TO_TURN = 34'sd683565276;
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [PROD_W-1:0] WORD_MAX = PROD_W'(64'sd2147483647);
  localparam logic signed [PROD_W-1:0] WORD_MIN = -PROD_W'(64'sd2147483648);

  typedef enum logic [4:0] {
    S_IDLE, S_ANG, S_ANG_DIV, S_ANG_WAIT, S_TRV, S_TRV_W, S_TURN, S_TURN_WAIT,
    S_ARC, S_ARC_WAIT, S_ROT, S_ROT_WAIT, S_VX, S_VY, S_AX, S_AY, S_VELX,
    S_VELY, S_FIN
  } ddo_state_t;

  typedef struct packed {
    logic                     en;
    logic signed [MUL_W-1:0]  a;
    logic signed [MUL_W-1:0]  b;
  } ddo_mul_req_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]         divisor;
  } ddo_div_req_t;

  function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [PROD_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > WORD_MAX) begin
      r = WORD_MAX[DATA_W-1:0];
    end else if (v < WORD_MIN) begin
      r = WORD_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // atan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'h20000000;
      5'd1:  r = 30'h12E4051E;
      5'd2:  r = 30'h09FB385B;
      5'd3:  r = 30'h051111D4;
      5'd4:  r = 30'h028B0D43;
      5'd5:  r = 30'h0145D7E1;
      5'd6:  r = 30'h00A2F61E;
      5'd7:  r = 30'h00517C55;
      5'd8:  r = 30'h0028BE53;
      5'd9:  r = 30'h00145F2F;
      5'd10: r = 30'h000A2F98;
      5'd11: r = 30'h000517CC;
      5'd12: r = 30'h00028BE6;
      5'd13: r = 30'h000145F3;
      5'd14: r = 30'h0000A2FA;
      5'd15: r = 30'h0000517D;
      5'd16: r = 30'h000028BE;
      5'd17: r = 30'h0000145F;
      5'd18: r = 30'h00000A30;
      5'd19: r = 30'h00000518;
      5'd20: r = 30'h0000028C;
      5'd21: r = 30'h00000146;
      5'd22: r = 30'h000000A3;
      5'd23: r = 30'h00000051;
      default: r = 30'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/differential_drive_odometry.sv
// ticks or distance input adds the two wheel conversion divides that radian mode skips
// a stalled output holds the sequencer in its final state until the output register is free
// each divide holds the sequencer on the shared radix-2 divider, each rotation on the cordic
// up to four divides (two wheel conversions, turn, arc) and twelve multiplies on one multiplier
// one item at a time; a finished result waits in the output register while the next runs
// synchronous reset clears position and heading and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none

module differential_drive_odometry
  import ddo_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [31:0]        left_increment,
  input  wire logic signed [31:0]        right_increment,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [31:0]             pos_x,
  output logic signed [31:0]             pos_y,
  output logic [31:0]                    heading_out,
  output logic signed [31:0]             vel_x,
  output logic signed [31:0]             vel_y,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_data
);

  ddo_state_t state, state_next;

  logic [1:0]  input_mode;
  logic [15:0] ticks_per_rev;
  logic [19:0] wheel_radius;
  logic [21:0] axle_track;
  logic [15:0] sample_rate;

  logic signed [31:0] inc_l, inc_r, wang, dl, dr, turn, arc;
  logic signed [TRIG_W-1:0] vx, vy, ax, ay;
  logic signed [31:0] velx;
  logic signed [31:0] position_x, position_y;
  logic [31:0] heading_angle;
  logic        side;

  ddo_mul_req_t mul_req;
  ddo_div_req_t div_req;
  logic signed [PROD_W-1:0] prod;
  logic                     div_done;
  logic signed [DIV_W-1:0]  quo;
  logic                     cor_start, cor_done;
  logic signed [TRIG_W-1:0] sin_v, cos_v;
  logic                     out_load;
  logic                     out_free;

  logic [15:0] ticks_eff;
  logic [19:0] radius_eff;
  logic [21:0] track_eff;
  logic signed [31:0] inc;
  logic signed [32:0] sum_lr, diff_lr, diff_rl;
  logic signed [31:0] vel_fwd;
  logic signed [PROD_W-1:0] quo_ext;

  ddo_mul u_mul (.clk(clk), .req(mul_req), .prod(prod));
  ddo_div u_div (.clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(quo));
  ddo_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .angle(heading_angle),
    .done(cor_done), .sin_val(sin_v), .cos_val(cos_v)
  );

  // zero tick, radius and track settings act as one
  assign ticks_eff  = (ticks_per_rev == '0) ? 16'd1 : ticks_per_rev;
  assign radius_eff = (wheel_radius == '0) ? 20'd1 : wheel_radius;
  assign track_eff  = (axle_track == '0) ? 22'd1 : axle_track;

  assign inc     = side ? inc_r : inc_l;
  assign sum_lr  = 33'(dl) + 33'(dr);
  assign diff_lr = 33'(dl) - 33'(dr);
  assign diff_rl = 33'(dr) - 33'(dl);
  assign vel_fwd = sum_lr[32:1];
  assign quo_ext = PROD_W'(quo);

  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_mode    <= MODE_TICKS;
      ticks_per_rev <= TICKS_RESET;
      wheel_radius  <= RADIUS_RESET;
      axle_track    <= TRACK_RESET;
      sample_rate   <= RATE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INPUT_MODE:    input_mode    <= cfg_data[1:0];
        CFG_TICKS_PER_REV: ticks_per_rev <= cfg_data[15:0];
        CFG_WHEEL_RADIUS:  wheel_radius  <= cfg_data[19:0];
        CFG_AXLE_TRACK:    axle_track    <= cfg_data[21:0];
        CFG_SAMPLE_RATE:   sample_rate   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_ANG;
      S_ANG: begin
        if (input_mode == MODE_TICKS || input_mode == MODE_DISTANCE) begin
          state_next = S_ANG_DIV;
        end else begin
          state_next = S_TRV;
        end
      end
      S_ANG_DIV:   state_next = S_ANG_WAIT;
      S_ANG_WAIT:  if (div_done) state_next = S_TRV;
      S_TRV:       state_next = S_TRV_W;
      S_TRV_W:     state_next = side ? S_TURN : S_ANG;
      S_TURN:      state_next = S_TURN_WAIT;
      S_TURN_WAIT: if (div_done) state_next = S_ARC;
      S_ARC:       state_next = S_ARC_WAIT;
      S_ARC_WAIT:  if (div_done) state_next = S_ROT;
      S_ROT:       state_next = S_ROT_WAIT;
      S_ROT_WAIT:  if (cor_done) state_next = S_VX;
      S_VX:        state_next = S_VY;
      S_VY:        state_next = S_AX;
      S_AX:        state_next = S_AY;
      S_AY:        state_next = S_VELX;
      S_VELX:      state_next = S_VELY;
      S_VELY:      state_next = S_FIN;
      S_FIN:       if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall         = 1'b1;
    mul_req          = '0;
    div_req          = '0;
    cor_start        = 1'b0;
    out_load         = 1'b0;
    unique case (state)
      S_IDLE: in_stall = 1'b0;
      S_ANG: begin
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(inc);
        mul_req.b  = TWO_PI_Q;
      end
      S_ANG_DIV: begin
        div_req.start = 1'b1;
        if (input_mode == MODE_TICKS) begin
          div_req.dividend = prod[DIV_W-1:0];
          div_req.divisor  = DVS_W'(ticks_eff);
        end else begin
          div_req.dividend = {{16{inc[31]}}, inc, 16'b0};
          div_req.divisor  = DVS_W'(radius_eff);
        end
      end
      S_TRV: begin
        mul_req.en = 1'b1;
        mul_req.a  = $signed({14'b0, radius_eff});
        mul_req.b  = MUL_W'(wang);
      end
      S_TURN: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{15{diff_rl[32]}}, diff_rl, 16'b0};
        div_req.divisor  = DVS_W'(track_eff);
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(sat_word(PROD_W'(diff_lr)));
        mul_req.b  = MUL_W'(sat_word(PROD_W'(sum_lr)));
      end
      S_ARC: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[DIV_W-1:0];
        div_req.divisor  = {track_eff, 1'b0};
        mul_req.en = 1'b1;
        mul_req.a  = MUL_W'(turn);
        mul_req.b  = RAD_TO_TURN;
      end
      S_ROT: cor_start = 1'b1;
      S_VX: begin
        mul_req.en = 1'b1;
        mul_req.a  = sin_v;
        mul_req.b  = MUL_W'(vel_fwd);
      end
      S_VY: begin
        mul_req.en = 1'b1;
        mul_req.a  = cos_v;
        mul_req.b  = MUL_W'(vel_fwd);
      end
      S_AX: begin
        mul_req.en = 1'b1;
        mul_req.a  = cos_v;
        mul_req.b  = MUL_W'(arc);
      end
      S_AY: begin
        mul_req.en = 1'b1;
        mul_req.a  = -sin_v;
        mul_req.b  = MUL_W'(arc);
      end
      S_VELX: begin
        mul_req.en = 1'b1;
        mul_req.a  = vx;
        mul_req.b  = $signed({18'b0, sample_rate});
      end
      S_VELY: begin
        mul_req.en = 1'b1;
        mul_req.a  = vy;
        mul_req.b  = $signed({18'b0, sample_rate});
      end
      S_FIN: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      position_x    <= '0;
      position_y    <= '0;
      heading_angle <= '0;
      side          <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid  <= 1'b1;
        position_x <= position_x + vx[31:0] + ax[32:1];
        position_y <= position_y + vy[31:0] + ay[32:1];
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE) begin
        side <= 1'b0;
      end else if (state == S_TRV_W) begin
        side <= 1'b1;
      end
      // heading takes the turn as a binary angle, wrapping
      if (state == S_ARC_WAIT && div_done) begin
        heading_angle <= heading_angle + prod[47:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      inc_l <= left_increment;
      inc_r <= right_increment;
    end
    if (state == S_ANG && input_mode != MODE_TICKS && input_mode != MODE_DISTANCE) begin
      wang <= inc;
    end
    if (state == S_ANG_WAIT && div_done) begin
      wang <= (input_mode == MODE_TICKS) ? sat_word(quo_ext >>> FRAC_BITS) : sat_word(quo_ext);
    end
    if (state == S_TRV_W) begin
      if (side) begin
        dr <= sat_word(prod >>> FRAC_BITS);
      end else begin
        dl <= sat_word(prod >>> FRAC_BITS);
      end
    end
    if (state == S_TURN_WAIT && div_done) begin
      turn <= sat_word(quo_ext);
    end
    if (state == S_ARC_WAIT && div_done) begin
      arc <= sat_word(quo_ext);
    end
    if (state == S_VY)   vx   <= prod[63:30];
    if (state == S_AX)   vy   <= prod[63:30];
    if (state == S_AY)   ax   <= prod[63:30];
    if (state == S_VELX) ay   <= prod[63:30];
    if (state == S_VELY) velx <= sat_word(prod);
    if (out_load) begin
      pos_x       <= position_x + vx[31:0] + ax[32:1];
      pos_y       <= position_y + vy[31:0] + ay[32:1];
      heading_out <= heading_angle;
      vel_x       <= velx;
      vel_y       <= sat_word(prod);
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ddo_mul.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_mul
  import ddo_pkg::*;
(
  input  wire logic                       clk,
  input  wire ddo_mul_req_t               req,
  output logic signed [PROD_W-1:0]        prod
);

  // product holds until the next issue
  always_ff @(posedge clk) begin
    if (req.en) begin
      prod <= req.a * req.b;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ddo_div.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_div
  import ddo_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ddo_div_req_t          req,
  output logic                       done,
  output logic signed [DIV_W-1:0]    quotient
);

  logic                busy;
  logic [5:0]          cnt;
  logic                neg;
  logic [DIV_W-1:0]    quo;
  logic [DVS_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs;
  logic [DVS_W:0]      rem_sh;
  logic [DVS_W:0]      rem_sub;
  logic                take;

  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign take    = rem_sh >= {1'b0, dvs};

  // truncating signed quotient, divisor is always positive
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[DIV_W-1];
      quo <= req.dividend[DIV_W-1] ? DIV_W'(-req.dividend) : DIV_W'(req.dividend);
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= take ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo <= {quo[DIV_W-2:0], take};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ddo_cordic.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_cordic
  import ddo_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [31:0]           angle,
  output logic                       done,
  output logic signed [TRIG_W-1:0]   sin_val,
  output logic signed [TRIG_W-1:0]   cos_val
);

  logic                     busy;
  logic [4:0]               idx;
  logic [1:0]               quad;
  logic signed [TRIG_W-1:0] x;
  logic signed [TRIG_W-1:0] y;
  logic signed [32:0]       z;
  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  logic signed [32:0]       step;

  assign dx   = y >>> idx;
  assign dy   = x >>> idx;
  assign step = $signed({3'b000, atan_turn(idx)});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (busy) begin
        idx <= idx + 5'd1;
        if (idx == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({3'b000, angle[29:0]});
      quad <= angle[31:30];
    end else if (busy) begin
      if (!z[32]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - step;
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + step;
      end
    end
  end

  // rotate the first-quadrant result back into place
  always_comb begin
    case (quad)
      2'd0: begin
        cos_val = x;
        sin_val = y;
      end
      2'd1: begin
        cos_val = -y;
        sin_val = x;
      end
      2'd2: begin
        cos_val = -x;
        sin_val = -y;
      end
      default: begin
        cos_val = y;
        sin_val = -x;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/ddo_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ddo_checker
  import ddo_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic signed [31:0]     pos_x,
  input wire logic [31:0]            heading_out
);

  // after reset the block is empty and ready
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // one item at a time: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while busy");

  // a fresh result only comes out of a busy sequencer
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(pos_x) && $stable(heading_out))
    else $error("stalled result changed");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

`default_nettype wire

### tb/sv/tb_differential_drive_odometry.sv
`timescale 1ns / 1ps

module tb_differential_drive_odometry;
  import ddo_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] left;
    logic signed [31:0] right;
  } wheel_beat_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [31:0]        hdg;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] left_increment = '0;
  logic signed [31:0] right_increment = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic [31:0] heading_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  differential_drive_odometry u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .left_increment(left_increment), .right_increment(right_increment),
    .out_valid(out_valid), .out_stall(out_stall),
    .pos_x(pos_x), .pos_y(pos_y), .heading_out(heading_out),
    .vel_x(vel_x), .vel_y(vel_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state and register copies
  logic [1:0]  m_mode;
  logic [15:0] m_ticks;
  logic [19:0] m_radius;
  logic [21:0] m_track;
  logic [15:0] m_rate;
  longint      m_px, m_py;
  logic [31:0] m_hdg;

  wheel_beat_t wheel_q[$];
  pose_t       pose_q[$];
  int errors = 0;
  int sender_idle = 0;
  int receiver_idle = 0;
  bit hold_sender = 0;
  longint cycles = 0;

  function automatic longint fshr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint wrap32(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  function automatic longint to_wheel_angle(longint inc);
    longint w, t, r;
    t = (m_ticks == 0) ? 1 : m_ticks;
    r = (m_radius == 0) ? 1 : m_radius;
    if (m_mode == MODE_TICKS) w = fshr((inc * 411774) / t, FRAC_BITS);
    else if (m_mode == MODE_DISTANCE) w = (inc * 65536) / r;
    else w = inc;
    return sat32(w);
  endfunction

  function automatic longint atan_at(int i);
    longint tab[24] = '{
      'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
      'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
      'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
      'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};
    return tab[i];
  endfunction

  function automatic pose_t advance_pose(wheel_beat_t b);
    longint wl, wr, r, l2, dl, dr, v, turn, arc, s, c, x, y, z, tx, ty;
    longint ax, ay, vx, vy;
    logic [31:0] dh;
    pose_t p;
    wl = to_wheel_angle(longint'(b.left));
    wr = to_wheel_angle(longint'(b.right));
    r = (m_radius == 0) ? 1 : m_radius;
    l2 = (m_track == 0) ? 1 : m_track;
    dl = sat32(fshr(r * wl, FRAC_BITS));
    dr = sat32(fshr(r * wr, FRAC_BITS));
    v = sat32(fshr(dl + dr, 1));
    turn = sat32(((dr - dl) * 65536) / l2);
    arc = sat32((sat32(dl - dr) * sat32(dl + dr)) / (2 * l2));
    tx = fshr(turn * 683565276, FRAC_BITS);
    dh = tx[31:0];
    m_hdg = m_hdg + dh;
    // cordic on the angle within its quadrant
    x = 652032874; y = 0; z = longint'(m_hdg[29:0]);
    for (int i = 0; i < 24; i++) begin
      tx = fshr(y, i);
      ty = fshr(x, i);
      if (z >= 0) begin
        x -= tx; y += ty; z -= atan_at(i);
      end else begin
        x += tx; y -= ty; z += atan_at(i);
      end
    end
    case (m_hdg[31:30])
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    ax = fshr(c * arc, 30);
    ay = fshr(-s * arc, 30);
    vx = fshr(s * v, 30);
    vy = fshr(c * v, 30);
    m_px = wrap32(m_px + vx + fshr(ax, 1));
    m_py = wrap32(m_py + vy + fshr(ay, 1));
    p.px = m_px[31:0];
    p.py = m_py[31:0];
    p.hdg = m_hdg;
    tx = sat32(vx * longint'(m_rate));
    ty = sat32(vy * longint'(m_rate));
    p.vx = tx[31:0];
    p.vy = ty[31:0];
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pose_q.push_back(advance_pose({left_increment, right_increment}));
        void'(wheel_q.pop_front());
      end
      if (!(in_valid && in_stall)) begin
        if (wheel_q.size() > (in_valid && !in_stall ? 0 : 0) && !hold_sender &&
            $urandom_range(99) >= sender_idle) begin
          in_valid <= 1'b1;
          left_increment <= wheel_q[0].left;
          right_increment <= wheel_q[0].right;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < receiver_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    pose_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{pos_x, pos_y, heading_out, vel_x, vel_y};
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pose_q.pop_front();
        if (got.px !== want.px) begin
          $display("%0t: pos_x expected %0d actual %0d", $time, want.px, got.px);
          errors++;
        end
        if (got.py !== want.py) begin
          $display("%0t: pos_y expected %0d actual %0d", $time, want.py, got.py);
          errors++;
        end
        if (got.hdg !== want.hdg) begin
          $display("%0t: heading_out expected %h actual %h", $time, want.hdg, got.hdg);
          errors++;
        end
        if (got.vx !== want.vx) begin
          $display("%0t: vel_x expected %0d actual %0d", $time, want.vx, got.vx);
          errors++;
        end
        if (got.vy !== want.vy) begin
          $display("%0t: vel_y expected %0d actual %0d", $time, want.vy, got.vy);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_INPUT_MODE:    m_mode = val[1:0];
      CFG_TICKS_PER_REV: m_ticks = val[15:0];
      CFG_WHEEL_RADIUS:  m_radius = val[19:0];
      CFG_AXLE_TRACK:    m_track = val[21:0];
      CFG_SAMPLE_RATE:   m_rate = val[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (wheel_q.size() != 0 || pose_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic push_beat(input logic [31:0] l, input logic [31:0] r);
    wheel_q.push_back('{l, r});
  endtask

  function automatic logic [31:0] rand_wheel();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(65535)) - 32768);
      2: return 32'($signed($urandom_range(400000)) - 200000);
      3: return {{12{1'($urandom_range(1))}}, 20'($urandom())};
      default: return 32'($signed($urandom_range(6000)) - 3000);
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [31:0] l;
    for (int i = 0; i < n; i++) begin
      l = rand_wheel();
      // mostly gentle motion with some turning
      if ($urandom_range(3) != 0) push_beat(l, l + 32'($signed($urandom_range(2000)) - 1000));
      else push_beat(l, rand_wheel());
    end
  endtask

  initial begin
    m_mode = MODE_TICKS; m_ticks = TICKS_RESET; m_radius = RADIUS_RESET;
    m_track = TRACK_RESET; m_rate = RATE_RESET;
    m_px = 0; m_py = 0; m_hdg = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed, default registers
    push_beat(32'h0, 32'h0);
    push_beat(32'h7fffffff, 32'h7fffffff);
    push_beat(32'h80000000, 32'h80000000);
    push_beat(32'h7fffffff, 32'h80000000);
    push_beat(32'h80000000, 32'h7fffffff);
    push_beat(32'd100, 32'd120);
    push_beat(32'hffffffff, 32'h1);
    wait_idle();
    write_reg(CFG_INPUT_MODE, CFG_DATA_W'(MODE_RADIANS));
    push_beat(32'h00010000, 32'h00010000);
    push_beat(32'h0, 32'h0001921f);
    push_beat(32'hfff00000, 32'h00100000);
    wait_idle();
    write_reg(CFG_INPUT_MODE, 22'd3);
    push_beat(32'h00008000, 32'hffff0000);
    wait_idle();
    write_reg(CFG_INPUT_MODE, CFG_DATA_W'(MODE_DISTANCE));
    write_reg(CFG_WHEEL_RADIUS, 22'd0);
    write_reg(CFG_AXLE_TRACK, 22'd0);
    push_beat(32'h7fffffff, 32'h80000000);
    push_beat(32'd1000, 32'd999);
    wait_idle();
    write_reg(CFG_INPUT_MODE, CFG_DATA_W'(MODE_TICKS));
    write_reg(CFG_TICKS_PER_REV, 22'd0);
    write_reg(CFG_SAMPLE_RATE, 22'd0);
    write_reg(CFG_WHEEL_RADIUS, 22'hfffff);
    write_reg(CFG_AXLE_TRACK, 22'h3fffff);
    push_beat(32'h7fffffff, 32'h12345678);
    push_beat(32'h80000000, 32'h00000001);
    wait_idle();
    write_reg(3'd5, 22'h3fffff);
    write_reg(3'd7, 22'h1);
    write_reg(CFG_TICKS_PER_REV, 22'hffff);
    write_reg(CFG_SAMPLE_RATE, 22'hffff);
    push_beat(32'h00400000, 32'h00500000);
    push_beat(32'hdeadbeef, 32'h0badf00d);
    wait_idle();

    // random phases with varying idling and register settings
    for (int ph = 0; ph < 8; ph++) begin
      sender_idle = (ph < 3) ? 7 : (ph < 6) ? 65 : 0;
      receiver_idle = (ph < 3) ? 65 : (ph < 6) ? 7 : 0;
      write_reg(CFG_INPUT_MODE, 22'($urandom_range(3)));
      write_reg(CFG_TICKS_PER_REV, 22'($urandom_range(1) ? $urandom_range(65535) : 500));
      write_reg(CFG_WHEEL_RADIUS, 22'($urandom_range(1) ? $urandom_range(1048575) : 4260));
      write_reg(CFG_AXLE_TRACK,
                22'($urandom_range(1) ? $urandom_range(4194303) : 21627));
      write_reg(CFG_SAMPLE_RATE, 22'($urandom_range(1) ? $urandom_range(65535) : 100));
      random_phase(50);
      if (ph == 4) begin
        // sender holds off until the block has drained
        while (wheel_q.size() != 0) @(posedge clk);
        hold_sender = 1;
        random_phase(5);
        while (pose_q.size() != 0) @(posedge clk);
        hold_sender = 0;
      end
      random_phase(45);
      wait_idle();
    end
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
